### hw/rtl/interval_set_tracker_core_defines.svh
// assertion macros shared by the interval set tracker rtl
// no dependencies; expects clk and arst_n in the including scope
`ifndef INTERVAL_SET_TRACKER_CORE_DEFINES_SVH
`define INTERVAL_SET_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define IST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ist_pkg.sv
// types and codes for the interval set tracker
// no dependencies
package ist_pkg;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2
	} command_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_REMOVE,
		OP_QUERY,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_EVAL,
		S_EXTRA,
		S_FINAL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic start;
		logic eval;
		logic extra;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic done;
		logic need_extra;
	} dp_stat_t;

endpackage

### hw/rtl/ist_ram.sv
// generic single write port ram with registered read
// no dependencies
module ist_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/ist_ctrl.sv
// sequencer for the interval set tracker: walks the table one entry at a time
// depends on ist_pkg
module ist_ctrl
	import ist_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_CHECK;
			S_CHECK: state_d = stat.done ? S_FINAL : S_EVAL;
			S_EVAL:  state_d = stat.need_extra ? S_EXTRA : S_CHECK;
			S_EXTRA: state_d = S_CHECK;
			S_FINAL: state_d = S_RESP;
			S_RESP:  if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		out_valid  = (state_q == S_RESP);
		cmd.start  = (state_q == S_IDLE) && in_valid;
		cmd.eval   = (state_q == S_EVAL);
		cmd.extra  = (state_q == S_EXTRA);
		cmd.finish = (state_q == S_FINAL);
	end

endmodule

### hw/rtl/ist_datapath.sv
// datapath: two table banks, scan pointers, merge/split logic and result word
// depends on ist_pkg and ist_ram
module ist_datapath
	import ist_pkg::*;
#(
	parameter int MAX_INTERVALS = 64,
	parameter int COORD_WIDTH   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_stat_t               stat,
	input  logic [1:0]             command,
	input  logic [COORD_WIDTH-1:0] range_start,
	input  logic [COORD_WIDTH-1:0] range_end,
	output logic                   covered,
	output logic [1:0]             status
);

	localparam int AW   = $clog2(MAX_INTERVALS);
	localparam int CNTW = $clog2(MAX_INTERVALS + 2);
	localparam int DW   = 2 * COORD_WIDTH;

	logic [COORD_WIDTH-1:0] s_q, e_q, ns_q, ne_q;
	logic [CNTW-1:0]        k_q, out_q, count_q;
	logic                   bank_q, emitted_q, cov_q, empty_q;
	op_t                    op_q;

	logic [DW-1:0] rd0, rd1, rd_data, wr_word;
	logic [COORD_WIDTH-1:0] rs, re;
	logic add_left, add_touch, rem_ovl, lo, hi;
	logic wr_want, wr_en;
	logic [CNTW-1:0] new_cnt;
	logic full;

	assign rd_data = bank_q ? rd1 : rd0;
	assign rs = rd_data[DW-1:COORD_WIDTH];
	assign re = rd_data[COORD_WIDTH-1:0];

	assign add_left  = re < s_q;
	assign add_touch = rs <= e_q;
	assign rem_ovl   = (re > s_q) && (rs < e_q);
	assign lo        = rs < s_q;
	assign hi        = re > e_q;

	assign stat.done = (op_q == OP_NONE) || (k_q == count_q);
	assign stat.need_extra =
		((op_q == OP_ADD) && !add_left && !add_touch && !emitted_q) ||
		((op_q == OP_REMOVE) && rem_ovl && lo && hi);

	// one output word per write; the stream goes into the idle bank
	always_comb begin
		wr_want = 1'b0;
		wr_word = rd_data;
		if (cmd.eval) begin
			case (op_q)
				OP_ADD: begin
					if (add_left) begin
						wr_want = 1'b1;
					end else if (!add_touch) begin
						wr_want = 1'b1;
						if (!emitted_q) wr_word = {ns_q, ne_q};
					end
				end
				OP_REMOVE: begin
					if (!rem_ovl) begin
						wr_want = 1'b1;
					end else if (lo) begin
						wr_want = 1'b1;
						wr_word = {rs, s_q};
					end else if (hi) begin
						wr_want = 1'b1;
						wr_word = {e_q, re};
					end
				end
				default: wr_want = 1'b0;
			endcase
		end else if (cmd.extra) begin
			wr_want = 1'b1;
			wr_word = (op_q == OP_ADD) ? {rs, re} : {e_q, re};
		end else if (cmd.finish) begin
			wr_want = (op_q == OP_ADD) && !emitted_q;
			wr_word = {ns_q, ne_q};
		end
	end

	// writes past capacity are dropped; such a pass is never committed
	assign wr_en   = wr_want && (out_q < CNTW'(MAX_INTERVALS));
	assign new_cnt = out_q + CNTW'(wr_want);
	assign full    = new_cnt > CNTW'(MAX_INTERVALS);

	ist_ram #(.WIDTH(DW), .DEPTH(MAX_INTERVALS)) u_bank0 (
		.clk   (clk),
		.we    (wr_en && bank_q),
		.waddr (out_q[AW-1:0]),
		.wdata (wr_word),
		.raddr (k_q[AW-1:0]),
		.rdata (rd0)
	);

	ist_ram #(.WIDTH(DW), .DEPTH(MAX_INTERVALS)) u_bank1 (
		.clk   (clk),
		.we    (wr_en && !bank_q),
		.waddr (out_q[AW-1:0]),
		.wdata (wr_word),
		.raddr (k_q[AW-1:0]),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			out_q     <= '0;
			count_q   <= '0;
			bank_q    <= 1'b0;
			emitted_q <= 1'b0;
			cov_q     <= 1'b0;
			empty_q   <= 1'b0;
			op_q      <= OP_NONE;
			covered   <= 1'b0;
			status    <= ST_OK;
		end else begin
			if (cmd.start) begin
				k_q       <= '0;
				out_q     <= '0;
				emitted_q <= 1'b0;
				cov_q     <= 1'b0;
				empty_q   <= range_start >= range_end;
				if (range_start >= range_end) begin
					op_q <= OP_NONE;
				end else begin
					case (command)
						CMD_ADD:    op_q <= OP_ADD;
						CMD_REMOVE: op_q <= OP_REMOVE;
						CMD_QUERY:  op_q <= OP_QUERY;
						default:    op_q <= OP_NONE;
					endcase
				end
			end
			if (cmd.eval || cmd.extra) begin
				out_q <= new_cnt;
			end
			if (cmd.eval) begin
				if (!stat.need_extra) k_q <= k_q + 1'b1;
				if (op_q == OP_ADD && !add_left && !add_touch) emitted_q <= 1'b1;
				if (op_q == OP_QUERY && rs <= s_q && e_q <= re) cov_q <= 1'b1;
			end
			if (cmd.extra) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.finish) begin
				covered <= 1'b0;
				status  <= ST_OK;
				if (empty_q) begin
					status <= ST_EMPTY;
				end else if (op_q == OP_QUERY) begin
					covered <= cov_q;
				end else if (op_q == OP_ADD || op_q == OP_REMOVE) begin
					if (full) begin
						status <= ST_FULL;
					end else begin
						count_q <= new_cnt;
						bank_q  <= !bank_q;
					end
				end
			end
		end
	end

	// range latch and merged bounds
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q  <= range_start;
			e_q  <= range_end;
			ns_q <= range_start;
			ne_q <= range_end;
		end else if (cmd.eval && op_q == OP_ADD && !add_left && add_touch) begin
			if (rs < ns_q) ns_q <= rs;
			if (re > ne_q) ne_q <= re;
		end
	end

endmodule

### hw/rtl/interval_set_tracker_core.sv
// interval set tracker top level: controller plus datapath
// depends on ist_pkg, ist_ctrl, ist_datapath and the assertion macro header
`include "interval_set_tracker_core_defines.svh"

// Keeps a sorted set of disjoint half-open intervals in two ping-pong table
// banks. Each add, remove or query word with a non-empty range scans the
// live bank entry by entry, reading one table entry at a time; an add or
// remove streams the rewritten table into the other bank, which becomes
// live when the operation succeeds. Inserting a new interval ahead of a
// later entry or splitting one takes an extra step. One word at a time: a
// new word is accepted only once the result has been taken. No clearing
// pass is needed after reset.
module interval_set_tracker_core
	import ist_pkg::*;
#(
	parameter int MAX_INTERVALS = 64,
	parameter int COORD_WIDTH   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [COORD_WIDTH-1:0] range_start,
	input  logic [COORD_WIDTH-1:0] range_end,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   covered,
	output logic [1:0]             status
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ist_datapath #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.COORD_WIDTH   (COORD_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.command     (command),
		.range_start (range_start),
		.range_end   (range_end),
		.covered     (covered),
		.status      (status)
	);

	`IST_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready, "accepted while result pending")
	`IST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accept did not busy")
	`IST_ASSERT_NEXT(a_idle_after_result, out_valid && out_ready, in_ready, "no return to idle")
	`IST_ASSERT_NOW(a_covered_ok, out_valid && covered, status == ST_OK, "covered with bad status")

endmodule

### tb/sv/interval_set_tracker_core_test.sv
// testbench for interval_set_tracker_core: random and directed add, remove and query words
// depends on ist_pkg and the rtl; an interval scoreboard class predicts every result
module interval_set_tracker_core_test;
	import ist_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	class interval_scoreboard;
		bit [31:0] lo_q[$];
		bit [31:0] hi_q[$];
		bit        cov_q[$];
		bit [1:0]  stat_q[$];
		int        errors;

		function bit [1:0] do_merge(bit [31:0] s, bit [31:0] e);
			int i, j;
			bit [31:0] ns, ne;
			i = 0;
			ns = s;
			ne = e;
			while (i < lo_q.size() && hi_q[i] < s) i++;
			j = i;
			while (j < lo_q.size() && lo_q[j] <= e) j++;
			if (j > i) begin
				if (lo_q[i] < ns) ns = lo_q[i];
				if (hi_q[j-1] > ne) ne = hi_q[j-1];
			end else if (lo_q.size() >= NSLOT) begin
				return ST_FULL;
			end
			for (int k = i; k < j; k++) begin
				lo_q.delete(i);
				hi_q.delete(i);
			end
			lo_q.insert(i, ns);
			hi_q.insert(i, ne);
			return ST_OK;
		endfunction

		function bit [1:0] do_cut(bit [31:0] s, bit [31:0] e);
			int i, j, np;
			bit [31:0] ps[2], pe[2];
			i = 0;
			np = 0;
			while (i < lo_q.size() && hi_q[i] <= s) i++;
			j = i;
			while (j < lo_q.size() && lo_q[j] < e) j++;
			if (j == i) return ST_OK;
			if (lo_q[i] < s) begin
				ps[np] = lo_q[i]; pe[np] = s; np++;
			end
			if (hi_q[j-1] > e) begin
				ps[np] = e; pe[np] = hi_q[j-1]; np++;
			end
			if (lo_q.size() - (j - i) + np > NSLOT) return ST_FULL;
			for (int k = i; k < j; k++) begin
				lo_q.delete(i);
				hi_q.delete(i);
			end
			for (int k = np - 1; k >= 0; k--) begin
				lo_q.insert(i, ps[k]);
				hi_q.insert(i, pe[k]);
			end
			return ST_OK;
		endfunction

		function void note_word(bit [1:0] cmd, bit [31:0] s, bit [31:0] e);
			bit c;
			bit [1:0] st;
			c = 0;
			st = ST_OK;
			if (s >= e) st = ST_EMPTY;
			else if (cmd == CMD_ADD) st = do_merge(s, e);
			else if (cmd == CMD_REMOVE) st = do_cut(s, e);
			else if (cmd == CMD_QUERY) begin
				foreach (lo_q[k]) if (lo_q[k] <= s && e <= hi_q[k]) c = 1;
			end
			cov_q.push_back(c);
			stat_q.push_back(st);
		endfunction

		function void check_word(bit c, bit [1:0] st);
			bit ec;
			bit [1:0] es;
			if (cov_q.size() == 0) begin
				$error("unexpected result word covered=%0d status=%0d", c, st);
				errors++;
				return;
			end
			ec = cov_q.pop_front();
			es = stat_q.pop_front();
			if (c !== ec) begin
				$error("covered: expected %0d actual %0d", ec, c);
				errors++;
			end
			if (st !== es) begin
				$error("status: expected %0d actual %0d", es, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0, covered;
	logic [1:0] command = 0, status;
	logic [31:0] range_start = 0, range_end = 0;
	interval_scoreboard sb = new();
	int idle_cycles = 0;
	bit hold_off = 0;

	always #1 clk = ~clk;

	interval_set_tracker_core dut (.*);

	// watchdog on cycles without any accepted word or taken result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_word(covered, status);
	end

	task automatic send_word(bit [1:0] cmd, bit [31:0] s, bit [31:0] e);
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		range_start <= s;
		range_end <= e;
		do @(posedge clk); while (!in_ready);
		sb.note_word(cmd, s, e);
		@(negedge clk);
	endtask

	// mostly small coordinates so intervals collide; some full-width values
	function automatic bit [31:0] pick_coord(int span);
		if ($urandom_range(0, 19) == 0) return $urandom();
		return $urandom_range(0, span);
	endfunction

	task automatic random_word(int span, int add_bias);
		bit [1:0] cmd;
		bit [31:0] s, e;
		int r;
		r = $urandom_range(0, 99);
		if (r < add_bias) cmd = CMD_ADD;
		else if (r < 75) cmd = CMD_REMOVE;
		else if (r < 98) cmd = CMD_QUERY;
		else cmd = CMD_UNUSED;
		s = pick_coord(span);
		if ($urandom_range(0, 15) == 0) e = pick_coord(span);
		else e = s + $urandom_range(1, span / 8 + 1);
		if (e < s && $urandom_range(0, 1)) e = 32'hffff_ffff;
		send_word(cmd, s, e);
	endtask

	// receiver: random stalls plus one long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			w = $urandom_range(0, 12);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w > 0) begin
				out_ready <= 0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, each command, empty ranges, unused command
		send_word(CMD_QUERY, 0, 1);
		send_word(CMD_REMOVE, 0, 10);
		send_word(CMD_ADD, 0, 32'hffff_ffff);
		send_word(CMD_QUERY, 0, 32'hffff_ffff);
		send_word(CMD_QUERY, 32'hffff_fffe, 32'hffff_ffff);
		send_word(CMD_REMOVE, 100, 200);
		send_word(CMD_QUERY, 50, 150);
		send_word(CMD_QUERY, 0, 100);
		send_word(CMD_ADD, 100, 200);
		send_word(CMD_ADD, 300, 400);
		send_word(CMD_ADD, 400, 500);
		send_word(CMD_REMOVE, 0, 32'hffff_ffff);
		send_word(CMD_ADD, 5, 5);
		send_word(CMD_REMOVE, 9, 3);
		send_word(CMD_QUERY, 32'hffff_ffff, 0);
		send_word(CMD_UNUSED, 1, 2);
		send_word(CMD_UNUSED, 32'haaaa_aaaa, 32'h5555_5555);
		send_word(CMD_ADD, 32'h5555_5555, 32'haaaa_aaaa);
		send_word(CMD_QUERY, 32'h5555_5555, 32'haaaa_aaaa);
		send_word(CMD_REMOVE, 0, 32'hffff_ffff);
		// fill the table to capacity with disjoint intervals, then overflow
		for (int k = 0; k < NSLOT + 2; k++) send_word(CMD_ADD, k * 10, k * 10 + 3);
		send_word(CMD_REMOVE, 11, 12);
		send_word(CMD_ADD, 20, 30);
		send_word(CMD_REMOVE, 0, 32'hffff_ffff);
		hold_off = 1;
		for (int n = 0; n < 860; n++) begin
			if (n % 200 == 0) random_word(200, 70);
			random_word((n % 300 < 150) ? 2000 : 300, (n % 400 < 200) ? 60 : 35);
		end
		in_valid <= 0;
		while (sb.cov_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
